// ===== rtl/ttb_pkg.sv =====
// ttb_pkg: shared types and constants of the terminal text buffer
// no dependencies; used by the channel interfaces and every rtl module
package ttb_pkg;

	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 16;
	localparam int INDEX_W  = 12;
	localparam int CAP_W    = 13;
	localparam int LEN_W    = 13;

	localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 16'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 16'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 16'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'd32;

	// tab stops; kept a power of two so the column phase is a mask
	localparam int TAB_INTERVAL = 8;
	localparam int CNT_W        = $clog2(TAB_INTERVAL + 1);

	localparam int CAP_RESET_VALUE = 4096;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PRINT = 3'd0,
		OP_CR    = 3'd1,
		OP_LF    = 3'd2,
		OP_BS    = 3'd3,
		OP_TAB   = 3'd4,
		OP_READ  = 3'd5,
		OP_CLEAR = 3'd6,
		OP_NOP   = 3'd7
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  char_code;
		logic [INDEX_W-1:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0] read_char;
		logic              read_in_range;
		logic [LEN_W-1:0]  content_length;
		logic [LEN_W-1:0]  line_length;
		logic [LEN_W-1:0]  cursor_column;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic cursor_ok;
	} back_stat_t;

endpackage

// ===== rtl/ttb_ifs.sv =====
// ttb_ifs: valid/ready channel interfaces of the terminal text buffer
// depends on ttb_pkg for the field widths
interface ttb_req_if import ttb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] read_index;

	modport source (output valid, output mode, output char_code, output read_index,
		input ready);
	modport sink (input valid, input mode, input char_code, input read_index,
		output ready);
endinterface

interface ttb_rsp_if import ttb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] read_char;
	logic              read_in_range;
	logic [LEN_W-1:0]  content_length;
	logic [LEN_W-1:0]  line_length;
	logic [LEN_W-1:0]  cursor_column;

	modport source (output valid, output read_char, output read_in_range,
		output content_length, output line_length, output cursor_column, input ready);
	modport sink (input valid, input read_char, input read_in_range,
		input content_length, input line_length, input cursor_column, output ready);
endinterface

interface ttb_cfg_if import ttb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity_in_use;

	modport source (output valid, output capacity_in_use, input ready);
	modport sink (input valid, input capacity_in_use, output ready);
endinterface

// ===== rtl/ttb_front.sv =====
// ttb_front: accepts request transfers and classifies them into commands
// depends on ttb_pkg; feeds ttb_queue
module ttb_front import ttb_pkg::*; (
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [MODE_W-1:0]  req_mode,
	input  logic [CHAR_W-1:0]  req_char_code,
	input  logic [INDEX_W-1:0] req_read_index,
	input  logic               q_full,
	output logic               q_push,
	output cmd_t               q_cmd
);

	op_t op;

	always_comb begin
		op = OP_NOP;
		unique case (req_mode)
			MODE_CHAR: begin
				unique case (req_char_code)
					CH_CR:   op = OP_CR;
					CH_LF:   op = OP_LF;
					CH_BS:   op = OP_BS;
					CH_TAB:  op = OP_TAB;
					default: op = OP_PRINT;
				endcase
			end
			MODE_READ:  op = OP_READ;
			MODE_CLEAR: op = OP_CLEAR;
			default:    op = OP_NOP;
		endcase
	end

	assign req_ready        = !q_full;
	assign q_push           = req_valid && !q_full;
	assign q_cmd.op         = op;
	assign q_cmd.char_code  = req_char_code;
	assign q_cmd.read_index = req_read_index;

endmodule

// ===== rtl/ttb_queue.sv =====
// ttb_queue: short command queue between the front and the back end
// depends on ttb_pkg for cmd_t and the queue depth
module ttb_queue import ttb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output cmd_t              head,
	output logic [QCNT_W-1:0] count
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign head    = entry_q[rd_ptr_q];
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/ttb_back.sv =====
// ttb_back: executes commands on the text ring, trims to capacity, holds the result
// depends on ttb_pkg; the ring memory and the capacity register live here
module ttb_back import ttb_pkg::*; #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_cap,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp_data,
	output back_stat_t       stat
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int LW = $clog2(STORE_DEPTH + 2);
	localparam int SW = LW + 1;
	localparam int CW = (LW > CAP_W) ? LW : CAP_W;
	localparam int CAP_INIT = (STORE_DEPTH < CAP_RESET_VALUE) ? STORE_DEPTH : CAP_RESET_VALUE;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_PUT  = 5'b00100,
		ST_TRIM = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [AW-1:0]     oldest_q, oldest_d;
	logic [LW-1:0]     hist_q, hist_d;
	logic [LW-1:0]     line_q, line_d;
	logic [LW-1:0]     cursor_q, cursor_d;
	logic              pending_q, pending_d;
	logic [LW-1:0]     cap_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CHAR_W-1:0] put_char_q, put_char_d;
	logic              rin_q, rin_d;
	logic [CHAR_W-1:0] rd_data_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CHAR_W-1:0] mem [STORE_DEPTH];
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [CHAR_W-1:0] wr_data;

	logic [LW-1:0]     total, excess, line_cut, cur_start;
	logic [CW-1:0]     cap_clamped;
	logic              load_rsp;

	// ring position of a content offset; offsets never reach twice the depth
	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
		input logic [LW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(STORE_DEPTH)) sum = sum - SW'(STORE_DEPTH);
		return sum[AW-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] out_len(input logic [LW-1:0] v);
		logic [CW-1:0] e;
		e = CW'(v);
		return e[LEN_W-1:0];
	endfunction

	assign total = hist_q + line_q;

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		oldest_d   = oldest_q;
		hist_d     = hist_q;
		line_d     = line_q;
		cursor_d   = cursor_q;
		pending_d  = pending_q;
		cnt_d      = cnt_q;
		put_char_d = put_char_q;
		rin_d      = rin_q;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		cmd_pop    = 1'b0;
		load_rsp   = 1'b0;
		excess     = '0;
		line_cut   = '0;
		cur_start  = pending_q ? '0 : cursor_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				rin_d = 1'b0;
				cnt_d = '0;
				unique case (cmd_q.op) inside
					OP_CR: begin
						cursor_d  = '0;
						pending_d = 1'b1;
						state_d   = ST_TRIM;
					end
					OP_LF: begin
						wr_en     = 1'b1;
						wr_addr   = wrap_addr(oldest_q, total);
						wr_data   = CH_LF;
						hist_d    = total + 1'b1;
						line_d    = '0;
						cursor_d  = '0;
						pending_d = 1'b0;
						state_d   = ST_TRIM;
					end
					OP_BS: begin
						if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
						state_d = ST_TRIM;
					end
					OP_TAB, OP_PRINT: begin
						// a pending carriage return empties the line first
						if (pending_q) begin
							line_d    = '0;
							cursor_d  = '0;
							pending_d = 1'b0;
						end
						if (cmd_q.op == OP_TAB) begin
							cnt_d = CNT_W'(TAB_INTERVAL)
								- CNT_W'(cur_start % LW'(TAB_INTERVAL));
							put_char_d = CH_SPACE;
						end else begin
							cnt_d      = CNT_W'(1);
							put_char_d = cmd_q.char_code;
						end
						state_d = ST_PUT;
					end
					OP_READ: begin
						if (CW'(cmd_q.read_index) < CW'(total)) begin
							rd_en   = 1'b1;
							rd_addr = wrap_addr(oldest_q, LW'(cmd_q.read_index));
							rin_d   = 1'b1;
						end
						state_d = ST_DONE;
					end
					OP_CLEAR: begin
						oldest_d  = '0;
						hist_d    = '0;
						line_d    = '0;
						cursor_d  = '0;
						pending_d = 1'b0;
						state_d   = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_data = put_char_q;
				if (cursor_q < line_q) begin
					wr_addr  = wrap_addr(oldest_q, hist_q + cursor_q);
					cursor_d = cursor_q + 1'b1;
				end else begin
					wr_addr  = wrap_addr(oldest_q, total);
					line_d   = line_q + 1'b1;
					cursor_d = line_q + 1'b1;
				end
				cnt_d   = cnt_q - 1'b1;
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				// drop from the front: history first, then the line and the cursor
				if (total > cap_q) begin
					excess = total - cap_q;
					if (excess <= hist_q) begin
						hist_d = hist_q - excess;
					end else begin
						hist_d   = '0;
						line_cut = excess - hist_q;
					end
					line_d   = line_q - line_cut;
					cursor_d = (cursor_q > line_cut) ? cursor_q - line_cut : '0;
					oldest_d = wrap_addr(oldest_q, excess);
				end
				state_d = (cnt_q != '0) ? ST_PUT : ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cap_clamped = CW'(cfg_cap);
		if (cap_clamped == '0) cap_clamped = CW'(1);
		else if (cap_clamped > CW'(STORE_DEPTH)) cap_clamped = CW'(STORE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		put_char_q <= put_char_d;
		rin_q      <= rin_d;
		if (load_rsp) begin
			rsp_q.read_char      <= rin_q ? rd_data_q : '0;
			rsp_q.read_in_range  <= rin_q;
			rsp_q.content_length <= out_len(total);
			rsp_q.line_length    <= out_len(line_q);
			rsp_q.cursor_column  <= out_len(cursor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			hist_q      <= '0;
			line_q      <= '0;
			cursor_q    <= '0;
			pending_q   <= 1'b0;
			cnt_q       <= '0;
			cap_q       <= LW'(CAP_INIT);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			oldest_q  <= oldest_d;
			hist_q    <= hist_d;
			line_q    <= line_d;
			cursor_q  <= cursor_d;
			pending_q <= pending_d;
			cnt_q     <= cnt_d;
			if (cfg_we) cap_q <= cap_clamped[LW-1:0];
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_data       = rsp_q;
	assign stat.idle      = state_q == ST_IDLE;
	assign stat.cursor_ok = cursor_q <= line_q;

endmodule

// ===== rtl/terminal_text_buffer.sv =====
// terminal_text_buffer: 16-bit character terminal store with CR, LF, BS and tab handling
// Back end per item: exec; then put and trim per character written (printable, tab), trim only
// (CR, BS, LF) or nothing (read, clear, unused mode); then done, which waits while a result is
// unaccepted. One item is in the back end at a time; each store write is followed by a trim.
// A two-entry queue accepts requests until full while the back end works or a result waits.
// Reset (arst_n low) clears lengths, cursor and ring pointer; the store itself is not cleared.
module terminal_text_buffer import ttb_pkg::*; #(
	parameter int STORE_DEPTH = 4096
) (
	input logic    clk,
	input logic    arst_n,
	ttb_req_if.sink   req,
	ttb_rsp_if.source rsp,
	ttb_cfg_if.sink   cfg
);

	logic              q_full, q_push, q_valid, q_pop;
	logic [QCNT_W-1:0] q_count;
	cmd_t              push_cmd, head_cmd;
	rsp_t              rsp_data;
	logic              rsp_valid;
	back_stat_t        stat;

	assign cfg.ready = 1'b1;

	ttb_front u_front (
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_mode       (req.mode),
		.req_char_code  (req.char_code),
		.req_read_index (req.read_index),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (push_cmd)
	);

	ttb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_cmd),
		.count    (q_count)
	);

	ttb_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.cfg_we    (cfg.valid),
		.cfg_cap   (cfg.capacity_in_use),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data),
		.stat      (stat)
	);

	assign rsp.valid          = rsp_valid;
	assign rsp.read_char      = rsp_data.read_char;
	assign rsp.read_in_range  = rsp_data.read_in_range;
	assign rsp.content_length = rsp_data.content_length;
	assign rsp.line_length    = rsp_data.line_length;
	assign rsp.cursor_column  = rsp_data.cursor_column;

	// cursor never runs past the end of the current line
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cursor_ok)
		else $error("cursor beyond line end");

	// an idle back end takes a queued command at once
	a_idle_takes_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle && q_valid |=> !stat.idle)
		else $error("queued command not taken by idle back end");

	// a full queue refuses new transfers
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_count == QCNT_W'(QUEUE_DEPTH) |-> !req.ready)
		else $error("request accepted into full queue");

	// a result only appears after the back end has worked on an item
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!stat.idle))
		else $error("result without a finished item");

endmodule
